@@ rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	// Default depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Fill codes of the sextet counter
	localparam logic [1:0] CNT_TWO   = 2'd2;
	localparam logic [1:0] CNT_THREE = 2'd3;

	// Result counts of one job
	localparam logic [1:0] RES_ONE   = 2'd1;
	localparam logic [1:0] RES_TWO   = 2'd2;
	localparam logic [1:0] RES_THREE = 2'd3;

	// Characters
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;

	// One decoded value: ok flag and the 6-bit value
	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sextet_t;

	// Work handed from front to back: up to three results of one character
	typedef struct packed {
		logic [23:0] data;    // byte 0 in the top bits
		logic [1:0]  cnt;     // results in this job, 1..3
		logic        empty;   // single result with no byte
		logic        fin;     // last result carries the end mark
		logic        halted;  // message halted as of this character
	} job_t;

	// Head of the queue as seen by the back
	typedef struct packed {
		logic valid;
		job_t job;
	} q_head_t;

	// Map a character onto its alphabet value; '=' and all else are not ok
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t s;
		s.ok  = 1'b1;
		s.val = 6'd0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			s.val = 6'(c - CH_UPPER_A);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			s.val = 6'(c - CH_LOWER_A + 8'd26);
		end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			s.val = 6'(c - CH_DIGIT_0 + 8'd52);
		end else if (c == CH_PLUS) begin
			s.val = 6'd62;
		end else if (c == CH_SLASH) begin
			s.val = 6'd63;
		end else begin
			s.ok = 1'b0;
		end
		return s;
	endfunction

endpackage

@@ rtl/b64d_char_if.sv @@
// ----------------------------------------------------------------------------
// b64d_char_if
// Input channel: one encoded character per word, with a last-character flag.
// ----------------------------------------------------------------------------
interface b64d_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       final_char;

	modport source (output valid, output char_in, output final_char, input ready);
	modport sink   (input valid, input char_in, input final_char, output ready);
endinterface

@@ rtl/b64d_byte_if.sv @@
// ----------------------------------------------------------------------------
// b64d_byte_if
// Output channel: one decoded byte or end mark per word.
// ----------------------------------------------------------------------------
interface b64d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic       byte_valid;
	logic       message_end;
	logic       halted_early;

	modport source (output valid, output byte_out, output byte_valid,
		output message_end, output halted_early, input ready);
	modport sink   (input valid, input byte_out, input byte_valid,
		input message_end, input halted_early, output ready);
endinterface

@@ rtl/base64_decoder_top.sv @@
// ----------------------------------------------------------------------------
// base64_decoder_top
// Streaming base64 decoder: characters in, decoded bytes and end marks out.
// ----------------------------------------------------------------------------
//  channel  | dir | word contents
//  char_ch  | in  | char_in[7:0], final_char
//  byte_ch  | out | byte_out[7:0], byte_valid, message_end, halted_early
//
//  One character is taken each cycle while the job queue has room.
//  A completed group or message end gives up to three output words, sent
//  one per cycle by the back end while the receiver is ready; the queue
//  depth sets how long the input keeps flowing while the output stalls.
//  A job's first output word is sent from the registered queue head, after any earlier jobs.
//  Reset clears the group state and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module base64_decoder_top #(
	parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	b64d_char_if.sink   char_ch,
	b64d_byte_if.source byte_ch
);

	logic              push;
	logic              pop;
	logic              q_full;
	b64d_pkg::job_t    job;
	b64d_pkg::q_head_t head;

	b64d_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_ch (char_ch),
		.q_full  (q_full),
		.push    (push),
		.job     (job)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.job    (job),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	b64d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.byte_ch (byte_ch)
	);

endmodule

@@ rtl/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Classifies each character, keeps the partial group and builds a job of
// up to three results for every completed group or message end.
// ----------------------------------------------------------------------------
module b64d_front (
	input  logic               clk,
	input  logic               arst_n,
	b64d_char_if.sink          char_ch,
	input  logic               q_full,
	output logic               push,
	output b64d_pkg::job_t     job
);

	logic [17:0]       hold_q, hold_n;
	logic [1:0]        cnt_q, cnt_n;
	logic              halted_q, halted_n;
	logic              grp;
	logic              accept;
	b64d_pkg::sextet_t dec;

	assign char_ch.ready = !q_full;
	assign accept        = char_ch.valid && char_ch.ready;
	assign dec           = b64d_pkg::sextet_of(char_ch.char_in);

	// Next group state and the job for this character
	always_comb begin
		hold_n   = hold_q;
		cnt_n    = cnt_q;
		halted_n = halted_q;
		grp      = 1'b0;
		job      = '0;
		if (!halted_q) begin
			if (!dec.ok) begin
				halted_n = 1'b1;
			end else if (cnt_q == b64d_pkg::CNT_THREE) begin
				grp      = 1'b1;
				job.data = {hold_q, dec.val};
				job.cnt  = b64d_pkg::RES_THREE;
				hold_n   = '0;
				cnt_n    = '0;
			end else begin
				hold_n = {hold_q[11:0], dec.val};
				cnt_n  = cnt_q + 2'd1;
			end
		end
		if (char_ch.final_char && !grp) begin
			case (cnt_n)
				b64d_pkg::CNT_TWO: begin
					job.data = {hold_n[11:4], 16'h0000};
					job.cnt  = b64d_pkg::RES_ONE;
				end
				b64d_pkg::CNT_THREE: begin
					job.data = {hold_n[17:10], hold_n[9:2], 8'h00};
					job.cnt  = b64d_pkg::RES_TWO;
				end
				default: begin
					job.cnt   = b64d_pkg::RES_ONE;
					job.empty = 1'b1;
				end
			endcase
		end
		job.fin    = char_ch.final_char;
		job.halted = halted_n;
	end

	assign push = accept && (grp || char_ch.final_char);

	// Group state; a final character clears it for the next message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= '0;
			cnt_q    <= '0;
			halted_q <= 1'b0;
		end else if (accept) begin
			if (char_ch.final_char) begin
				hold_q   <= '0;
				cnt_q    <= '0;
				halted_q <= 1'b0;
			end else begin
				hold_q   <= hold_n;
				cnt_q    <= cnt_n;
				halted_q <= halted_n;
			end
		end
	end

	// A group never completes on a halted message
	a_grp_not_halted: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && grp) |-> !job.halted)
		else $error("group completed after halt");

	// Halt is sticky until the message ends
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(halted_q && !(accept && char_ch.final_char)) |=> halted_q)
		else $error("halt dropped inside a message");

	// Every job holds one to three results
	a_job_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (job.cnt != 2'd0))
		else $error("empty job pushed");

endmodule

@@ rtl/b64d_queue.sv @@
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue that lets front and back stall independently.
// ----------------------------------------------------------------------------
module b64d_queue #(
	parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  b64d_pkg::job_t     job,
	input  logic               pop,
	output logic               full,
	output b64d_pkg::q_head_t  head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64d_pkg::job_t  entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.job   = entry_q[rd_ptr_q];

	// Storage write
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fill count lost a push");

endmodule

@@ rtl/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Walks the job at the queue head and sends its results one word at a time.
// ----------------------------------------------------------------------------
module b64d_back (
	input  logic               clk,
	input  logic               arst_n,
	input  b64d_pkg::q_head_t  head,
	output logic               pop,
	b64d_byte_if.source        byte_ch
);

	logic [1:0] idx_q;
	logic       last;
	logic [7:0] sel;

	assign last = (idx_q == head.job.cnt - 2'd1);

	// Byte select within the job
	always_comb begin
		case (idx_q)
			2'd0:    sel = head.job.data[23:16];
			2'd1:    sel = head.job.data[15:8];
			default: sel = head.job.data[7:0];
		endcase
	end

	assign byte_ch.valid        = head.valid;
	assign byte_ch.byte_out     = head.job.empty ? 8'h00 : sel;
	assign byte_ch.byte_valid   = !head.job.empty;
	assign byte_ch.message_end  = head.job.fin && last;
	assign byte_ch.halted_early = head.job.halted;

	assign pop = byte_ch.valid && byte_ch.ready && last;

	// Result index within the current job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (byte_ch.valid && byte_ch.ready) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> (idx_q < head.job.cnt))
		else $error("result index past job end");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head.valid |-> (idx_q == 2'd0))
		else $error("result index left over with empty queue");

	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		(head.valid && head.job.empty) |-> (head.job.cnt == 2'd1 && head.job.fin))
		else $error("malformed empty job");

endmodule

@@ verif/b64d_checker.sv @@
// ----------------------------------------------------------------------------
// b64d_checker
// Watches both channels of the base64 decoder. It decodes every accepted
// character on its own, queues the words that should come out, and compares
// each output word field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module b64d_checker (
	input  logic clk,
	input  logic arst_n,
	b64d_char_if char_ch,
	b64d_byte_if byte_ch,
	output int   fail_count,
	output int   pending,
	output int   words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// One output word as the decoder should send it
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic       halted;
	} byte_word_t;

	// Decoder state of the current message
	logic [17:0] dec_hold;
	logic [1:0]  dec_cnt;
	logic        dec_halted;

	byte_word_t expected_bytes[$];
	int         n_fail  = 0;
	int         n_words = 0;

	// Alphabet value of a character; bit 6 set when the character is in the alphabet
	function automatic logic [6:0] alphabet_value(input logic [7:0] c);
		if (c inside {[b64d_pkg::CH_UPPER_A:b64d_pkg::CH_UPPER_Z]}) begin
			return {1'b1, 6'(c - b64d_pkg::CH_UPPER_A)};
		end else if (c inside {[b64d_pkg::CH_LOWER_A:b64d_pkg::CH_LOWER_Z]}) begin
			return {1'b1, 6'(c - b64d_pkg::CH_LOWER_A + 8'd26)};
		end else if (c inside {[b64d_pkg::CH_DIGIT_0:b64d_pkg::CH_DIGIT_9]}) begin
			return {1'b1, 6'(c - b64d_pkg::CH_DIGIT_0 + 8'd52)};
		end else if (c == b64d_pkg::CH_PLUS) begin
			return {1'b1, 6'd62};
		end else if (c == b64d_pkg::CH_SLASH) begin
			return {1'b1, 6'd63};
		end
		return 7'd0;
	endfunction

	// Decode one character and queue the words it gives
	task automatic decode_char(input logic [7:0] c, input logic fin);
		logic [6:0]  sx;
		logic [23:0] grp;
		logic [7:0]  outb[3];
		int          nb;
		byte_word_t  w;

		nb = 0;
		sx = alphabet_value(c);
		if (!dec_halted) begin
			if (!sx[6]) begin
				dec_halted = 1'b1;
			end else if (dec_cnt == b64d_pkg::CNT_THREE) begin
				grp     = {dec_hold, sx[5:0]};
				outb[0] = grp[23:16];
				outb[1] = grp[15:8];
				outb[2] = grp[7:0];
				nb      = 3;
				dec_hold = '0;
				dec_cnt  = '0;
			end else begin
				dec_hold = {dec_hold[11:0], sx[5:0]};
				dec_cnt  = dec_cnt + 2'd1;
			end
		end

		// flush of a partial group at message end
		if (fin) begin
			if (dec_cnt == b64d_pkg::CNT_TWO) begin
				outb[0] = dec_hold[11:4];
				nb      = 1;
			end else if (dec_cnt == b64d_pkg::CNT_THREE) begin
				outb[0] = dec_hold[17:10];
				outb[1] = dec_hold[9:2];
				nb      = 2;
			end
		end

		for (int i = 0; i < nb; i++) begin
			w.data   = outb[i];
			w.valid  = 1'b1;
			w.last   = fin && (i == nb - 1);
			w.halted = dec_halted;
			expected_bytes.push_back(w);
		end

		if (fin) begin
			if (nb == 0) begin
				w = '{data: 8'h00, valid: 1'b0, last: 1'b1, halted: dec_halted};
				expected_bytes.push_back(w);
			end
			dec_hold   = '0;
			dec_cnt    = '0;
			dec_halted = 1'b0;
		end
	endtask

	// Compare one output word with the oldest expectation
	task automatic check_word();
		byte_word_t got, want;

		got.data   = byte_ch.byte_out;
		got.valid  = byte_ch.byte_valid;
		got.last   = byte_ch.message_end;
		got.halted = byte_ch.halted_early;
		n_words++;
		if (expected_bytes.size() == 0) begin
			n_fail++;
			$display("%0t: unexpected word: byte=%02h valid=%0b end=%0b halted=%0b",
				$time, got.data, got.valid, got.last, got.halted);
		end else begin
			want = expected_bytes.pop_front();
			if (got.data !== want.data || got.valid !== want.valid ||
				got.last !== want.last || got.halted !== want.halted) begin
				n_fail++;
				$display("%0t: word mismatch: expected byte=%02h valid=%0b end=%0b halted=%0b",
					$time, want.data, want.valid, want.last, want.halted);
				$display("%0t:                got      byte=%02h valid=%0b end=%0b halted=%0b",
					$time, got.data, got.valid, got.last, got.halted);
			end
		end
	endtask

	// Characters are decoded before words are checked; a word never leaves in
	// the cycle its character is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_hold   = '0;
			dec_cnt    = '0;
			dec_halted = 1'b0;
			expected_bytes.delete();
		end else begin
			if (char_ch.valid && char_ch.ready)
				decode_char(char_ch.char_in, char_ch.final_char);
			if (byte_ch.valid && byte_ch.ready)
				check_word();
		end
		fail_count    <= n_fail;
		pending       <= expected_bytes.size();
		words_checked <= n_words;
	end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the base64 decoder: directed corner messages, then random
// messages (mostly well-formed, some with stray padding or bad bytes) under
// changing sender gaps and receiver stalls, and one long output hold-off that
// fills the decoder and stalls its input. A checker instance does the scoring.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] CH_PAD      = 8'h3D;
	localparam int         STALL_LIMIT = 2000;
	localparam int         BURST_LEN   = 200;
	localparam int         PHASE_CHARS = 35;
	localparam int         PRESS_CHARS = 30;

	logic clk = 1'b0;
	logic arst_n;

	b64d_char_if char_ch ();
	b64d_byte_if byte_ch ();

	int fail_count;
	int pending;
	int words_checked;

	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int burst_req       = 0;
	int n_chars         = 0;
	int n_msgs          = 0;

	int sender_idle_by_phase[4] = '{0, 85, 0, 7};
	int recv_stall_by_phase[4]  = '{0, 0, 85, 7};

	base64_decoder_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_ch (char_ch),
		.byte_ch (byte_ch)
	);

	b64d_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_ch       (char_ch),
		.byte_ch       (byte_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_checked (words_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Random character from the base64 alphabet
	function automatic logic [7:0] b64_char();
		int v;
		v = $urandom_range(63);
		if (v < 26) return b64d_pkg::CH_UPPER_A + 8'(v);
		if (v < 52) return b64d_pkg::CH_LOWER_A + 8'(v - 26);
		if (v < 62) return b64d_pkg::CH_DIGIT_0 + 8'(v - 52);
		if (v == 62) return b64d_pkg::CH_PLUS;
		return b64d_pkg::CH_SLASH;
	endfunction

	// Offer one word after a random gap; returns at the edge it is taken.
	// valid stays high across back-to-back words.
	task automatic send_char(input logic [7:0] c, input logic fin);
		while ($urandom_range(99) < sender_idle_pct) begin
			char_ch.valid <= 1'b0;
			@(posedge clk);
		end
		char_ch.valid      <= 1'b1;
		char_ch.char_in    <= c;
		char_ch.final_char <= fin;
		do @(posedge clk); while (!char_ch.ready);
		n_chars++;
		if (fin) n_msgs++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// Random message: mostly whole groups with an optional padded tail,
	// otherwise noise with stray padding and out-of-alphabet bytes
	task automatic send_message(input int max_groups);
		logic [7:0] msg[$];
		int         n_groups, tail, len, k;

		if ($urandom_range(99) < 70) begin
			n_groups = $urandom_range(max_groups);
			tail     = $urandom_range(3);
			repeat (4 * n_groups + tail) msg.push_back(b64_char());
			if (tail != 0 && $urandom_range(1) == 1)
				repeat (4 - tail) msg.push_back(CH_PAD);
		end else begin
			len = $urandom_range(1, 10);
			repeat (len) begin
				k = $urandom_range(99);
				if (k < 75)
					msg.push_back(b64_char());
				else if (k < 85)
					msg.push_back(CH_PAD);
				else
					msg.push_back(8'($urandom_range(255)));
			end
		end
		if (msg.size() == 0) msg.push_back(b64_char());
		foreach (msg[i])
			send_char(msg[i], i == msg.size() - 1);
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		int burst_left;
		int burst_seen;
		burst_left = 0;
		burst_seen = 0;
		byte_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				byte_ch.ready <= 1'b0;
			end else if (burst_seen != burst_req) begin
				burst_seen = burst_req;
				burst_left = BURST_LEN;
				byte_ch.ready <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				byte_ch.ready <= 1'b0;
			end else begin
				byte_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: too long without any word moving on either channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (char_ch.valid && char_ch.ready) ||
				(byte_ch.valid && byte_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: watchdog expired, %0d cycles without progress", $time, STALL_LIMIT);
		$display("tb NOT OK");
		$finish;
	end

	// Main sequence
	initial begin
		int target;

		arst_n             = 1'b0;
		char_ch.valid      = 1'b0;
		char_ch.char_in    = 8'h00;
		char_ch.final_char = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full group, padded tails, lone value, bad bytes, alphabet ends
		send_text("TWFu");
		send_text("TQ==");
		send_text("TWE=");
		send_text("T");
		send_char(8'hFF, 1'b1);
		send_text("+/AZaz09");
		send_char(8'h80, 1'b0);
		send_char(b64d_pkg::CH_UPPER_A, 1'b1);    // ignored after the halt, only ends the message
		send_char(8'h00, 1'b1);

		// random messages under each gap/stall mix
		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = sender_idle_by_phase[p];
			recv_stall_pct  = recv_stall_by_phase[p];
			target = n_chars + PHASE_CHARS;
			while (n_chars < target) send_message(3);
		end

		// long output hold-off while characters keep coming
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		burst_req++;
		target = n_chars + PRESS_CHARS;
		while (n_chars < target) send_message(4);

		char_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d characters in %0d messages, %0d output words checked,",
			n_chars, n_msgs, words_checked);
		$display("under sender gaps, receiver stalls and one %0d-cycle output hold-off.",
			BURST_LEN);
		if (fail_count == 0 && pending == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

@@ base64_decoder_top.f @@
rtl/b64d_pkg.sv
rtl/b64d_char_if.sv
rtl/b64d_byte_if.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_decoder_top.sv
verif/b64d_checker.sv
verif/tb.sv
